// ===== design/jpeg_block_quantizer_core_assert.svh =====
// Assertion macros shared by the quantizer RTL.
`ifndef JPEG_BLOCK_QUANTIZER_CORE_ASSERT_SVH
`define JPEG_BLOCK_QUANTIZER_CORE_ASSERT_SVH

// Same-cycle implication under the clock, disabled while reset is asserted.
`define JBQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication under the clock, disabled while reset is asserted.
`define JBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== design/jbq_pkg.sv =====
package jbq_pkg;

	localparam int COEF_WIDTH = 12;
	localparam int ENTRY_W    = 7;
	localparam int QIDX_W     = 9;
	localparam int RECON_W    = 13;
	localparam int ZCNT_W     = 7;
	localparam int ERR_W      = 18;
	localparam int POS_W      = 6;
	localparam int SQ_W       = 2 * ENTRY_W;
	// Signed working width for the index and reconstruction before truncation.
	localparam int EXT_W      = (COEF_WIDTH + 1 > RECON_W) ? COEF_WIDTH + 1 : RECON_W;
	localparam int CNT_W      = $clog2(COEF_WIDTH);

	localparam logic [ZCNT_W-1:0] ZCNT_MAX  = '1;
	localparam logic [ERR_W-1:0]  ERR_MAX   = '1;
	localparam logic [POS_W-1:0]  LAST_POS  = '1;
	localparam logic [ZCNT_W-1:0] ZCNT_FULL = ZCNT_W'(64);

	localparam logic [ENTRY_W-1:0] LUMA_TABLE [64] = '{
		7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
		7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55,
		7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
		7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
		7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
		7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
		7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
		7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
	};

endpackage

// ===== design/jpeg_block_quantizer_core.sv =====
// JPEG luminance block quantizer.
// Input channel: coefficient with coef_valid/coef_stall. One word is one DCT
// coefficient; 64 words in row-major order make one 8x8 block, and a position
// counter picks the standard luminance table entry for each word.
// Output channel: quant_index, recon_value, block_done, zero_total, error_sum
// with result_valid/result_stall. Every input word gives exactly one result
// word. The 64th result of a block has block_done set and carries the zero
// count and the summed squared error; on other words those two fields are 0.
// A restoring divider produces one quotient bit per cycle. A word passes
// through an accept step, the divide steps and a finish step; coef_stall stays
// high until the finish step commits, and result_valid is registered there.
// The output register lets the next word be accepted while a result waits.
// If result_stall holds, the finish step waits and coef_stall stays high
// until the waiting result is taken. Reset clears the position, the block
// totals and all valids; the first word after reset is position 0.
module jpeg_block_quantizer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  coef_valid,
	output logic                                  coef_stall,
	input  logic signed [jbq_pkg::COEF_WIDTH-1:0] coefficient,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [jbq_pkg::QIDX_W-1:0]     quant_index,
	output logic signed [jbq_pkg::RECON_W-1:0]    recon_value,
	output logic                                  block_done,
	output logic        [jbq_pkg::ZCNT_W-1:0]     zero_total,
	output logic        [jbq_pkg::ERR_W-1:0]      error_sum
);
	import jbq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [POS_W-1:0]        position_q;
	logic [ZCNT_W-1:0]       zero_count_q;
	logic [ERR_W-1:0]        acc_q;
	logic [ENTRY_W-1:0]      entry_q;
	logic                    sign_q;
	logic [COEF_WIDTH-1:0]   dvd_q;
	logic [COEF_WIDTH-1:0]   quo_q;
	logic [ENTRY_W-1:0]      rem_q;

	logic                    coef_acc;
	logic                    commit;
	logic [ENTRY_W-1:0]      entry_sel;
	logic [COEF_WIDTH-1:0]   mag;
	logic [COEF_WIDTH-1:0]   dvd_in;
	logic [ENTRY_W:0]        shifted;
	logic [ENTRY_W+1:0]      trial;
	logic                    trial_ge;
	logic [COEF_WIDTH-1:0]   recon_mag;
	logic [EXT_W-1:0]        q_ext;
	logic [EXT_W-1:0]        r_ext;
	logic signed [ENTRY_W:0] err;
	logic [ENTRY_W-1:0]      err_abs;
	logic [SQ_W-1:0]         sq;
	logic [ERR_W:0]          acc_sum;
	logic [ERR_W-1:0]        acc_next;
	logic [ZCNT_W-1:0]       zc_next;
	logic                    last;

	assign coef_stall = (state_q != S_IDLE);
	assign coef_acc   = coef_valid && !coef_stall;
	assign commit     = (state_q == S_FIN) && (!result_valid || !result_stall);

	// Work on the magnitude; the rounding offset is half the table entry.
	assign entry_sel = LUMA_TABLE[position_q];
	assign mag       = coefficient[COEF_WIDTH-1] ? (~coefficient + 1'b1) : coefficient;
	assign dvd_in    = mag + COEF_WIDTH'(entry_sel[ENTRY_W-1:1]);

	// One restoring step: the remainder stays below the entry.
	assign shifted  = {rem_q, quo_q[COEF_WIDTH-1]};
	assign trial    = {1'b0, shifted} - {2'b00, entry_q};
	assign trial_ge = !trial[ENTRY_W+1];

	// index * entry equals the rounded dividend minus the remainder, and the
	// reconstruction error is the remainder minus half the entry.
	assign recon_mag = dvd_q - COEF_WIDTH'(rem_q);
	assign q_ext     = sign_q ? -EXT_W'(quo_q) : EXT_W'(quo_q);
	assign r_ext     = sign_q ? -EXT_W'(recon_mag) : EXT_W'(recon_mag);
	assign err       = signed'({1'b0, rem_q}) - signed'({2'b00, entry_q[ENTRY_W-1:1]});
	assign err_abs   = err[ENTRY_W] ? ENTRY_W'(-err) : err[ENTRY_W-1:0];
	assign sq        = err_abs * err_abs;
	assign acc_sum   = {1'b0, acc_q} + (ERR_W + 1)'(sq);
	assign acc_next  = acc_sum[ERR_W] ? ERR_MAX : acc_sum[ERR_W-1:0];
	assign zc_next   = ((quo_q == '0) && (zero_count_q != ZCNT_MAX)) ?
		zero_count_q + 1'b1 : zero_count_q;
	assign last      = (position_q == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			position_q   <= '0;
			zero_count_q <= '0;
			acc_q        <= '0;
			entry_q      <= '0;
			sign_q       <= 1'b0;
			dvd_q        <= '0;
			quo_q        <= '0;
			rem_q        <= '0;
			result_valid <= 1'b0;
			quant_index  <= '0;
			recon_value  <= '0;
			block_done   <= 1'b0;
			zero_total   <= '0;
			error_sum    <= '0;
		end else begin
			if (result_valid && !result_stall && !commit) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (coef_acc) begin
						entry_q <= entry_sel;
						sign_q  <= coefficient[COEF_WIDTH-1];
						dvd_q   <= dvd_in;
						quo_q   <= dvd_in;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= trial_ge ? trial[ENTRY_W-1:0] : shifted[ENTRY_W-1:0];
					quo_q <= {quo_q[COEF_WIDTH-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(COEF_WIDTH - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (commit) begin
						result_valid <= 1'b1;
						quant_index  <= signed'(q_ext[QIDX_W-1:0]);
						recon_value  <= signed'(r_ext[RECON_W-1:0]);
						block_done   <= last;
						zero_total   <= last ? zc_next : '0;
						error_sum    <= last ? acc_next : '0;
						zero_count_q <= last ? '0 : zc_next;
						acc_q        <= last ? '0 : acc_next;
						position_q   <= position_q + 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "jpeg_block_quantizer_core_assert.svh"

	`JBQ_ASSERT_NEXT(a_accept_starts_div, clk, arst_n, coef_acc, state_q == S_DIV && cnt_q == '0)
	`JBQ_ASSERT_IMPL(a_div_count_range, clk, arst_n, state_q == S_DIV,
		cnt_q <= CNT_W'(COEF_WIDTH - 1))
	`JBQ_ASSERT_IMPL(a_totals_only_at_end, clk, arst_n, result_valid && !block_done,
		zero_total == '0 && error_sum == '0)
	`JBQ_ASSERT_IMPL(a_zero_total_bound, clk, arst_n, result_valid && block_done,
		zero_total <= ZCNT_FULL)

endmodule
